>>> design/ccsds_packet_segmenter_defines.svh
// Assertion macros shared by the segmenter's checker files.
`ifndef CCSDS_PACKET_SEGMENTER_DEFINES_SVH
`define CCSDS_PACKET_SEGMENTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cps_pkg.sv
// Package with the shared constants and control types of the packet segmenter.
package cps_pkg;

	// Packet geometry.
	localparam int PAYLOAD_BYTES_DEF = 26;
	localparam int HEADER_BYTES      = 6;

	// Field widths.
	localparam int APID_W   = 11;
	localparam int FLAGS_W  = 2;
	localparam int SEQ_W    = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	// Register reset values.
	localparam logic [APID_W-1:0]  APID_RST  = 11'd35;
	localparam logic [FLAGS_W-1:0] FLAGS_RST = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_APID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAGS = 2'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // input transaction taken, store the byte
		logic start;    // the accepted byte completes a packet
		logic load;     // load the next packet byte into the output register
		logic finish;   // the loaded byte is the packet's last one
	} cps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic flush;     // the byte on the input would complete a packet
		logic last_idx;  // emission index points at the packet's last byte
		logic out_full;  // output register holds an untaken byte
	} cps_sts_t;

endpackage

>>> design/ccsds_packet_segmenter.sv
// CCSDS space packet segmenter: file bytes in, one byte a transaction; packets out,
// one byte a transaction, a 6-byte primary header first. A byte that does not complete a
// packet is stored in the buffer. A byte that fills the PAYLOAD_BYTES buffer or carries
// last_of_file starts emission of 6 + N bytes (N payload bytes) at one byte per cycle while
// the output is not stalled, through a single output register, and no input is taken until
// the last byte is loaded. The sequence count in the header advances per packet and wraps
// after 16383; restart_count clears it before its byte is handled. Configuration writes
// are always taken and must happen while idle.
module ccsds_packet_segmenter #(
	parameter int PAYLOAD_BYTES = cps_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cps_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_of_file,
	input  logic                           restart_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     packet_byte,
	output logic                           packet_end,
	output logic                           file_end
);
	import cps_pkg::*;

	cps_cmd_t cmd;
	cps_sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencing.
	cps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Buffering, header build and output.
	cps_datapath #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_byte    (data_byte),
		.last_of_file (last_of_file),
		.restart_count(restart_count),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.packet_byte  (packet_byte),
		.packet_end   (packet_end),
		.file_end     (file_end)
	);

endmodule

>>> design/cps_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 26,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/cps_datapath.sv
// Datapath of the packet segmenter: payload buffer, counters, header and output register.
module cps_datapath #(
	parameter int PAYLOAD_BYTES = cps_pkg::PAYLOAD_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cps_pkg::cps_cmd_t                 cmd,
	output cps_pkg::cps_sts_t                 sts,
	input  logic                              cfg_we,
	input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                        data_byte,
	input  logic                              last_of_file,
	input  logic                              restart_count,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        packet_byte,
	output logic                              packet_end,
	output logic                              file_end
);
	import cps_pkg::*;

	localparam int AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int FW = $clog2(PAYLOAD_BYTES + 1);
	localparam int IW = $clog2(PAYLOAD_BYTES + HEADER_BYTES + 1);

	logic [APID_W-1:0]  apid_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [FW-1:0]      fill_q;
	logic [FW-1:0]      fill_inc;
	logic [FW-1:0]      len_q;
	logic               last_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      idx_nxt;
	logic [IW-1:0]      idx_rd;
	logic [IW-1:0]      total_m1;
	logic [15:0]        len_word;
	logic [15:0]        seq_word;
	logic [7:0]         hdr [HEADER_BYTES];
	logic [7:0]         ram_rdata;
	logic [7:0]         next_byte;
	logic               out_valid_q;
	logic [7:0]         packet_byte_q;
	logic               packet_end_q;
	logic               file_end_q;

	// Configuration registers; the user must write them only while idle, which is not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apid_q  <= APID_RST;
			flags_q <= FLAGS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_APID:  apid_q  <= cfg_data[APID_W-1:0];
				REG_FLAGS: flags_q <= cfg_data[FLAGS_W-1:0];
				default:   ;
			endcase
		end
	end

	// A packet is due when the buffer fills or the file ends.
	assign fill_inc  = fill_q + FW'(1);
	assign sts.flush = (fill_inc == FW'(PAYLOAD_BYTES)) || last_of_file;

	// Fill count, packet length, sequence count and emission index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			last_q <= 1'b0;
			seq_q  <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.accept) begin
				fill_q <= cmd.start ? '0 : fill_inc;
				if (restart_count) begin
					seq_q <= '0;
				end
			end
			if (cmd.start) begin
				len_q  <= fill_inc;
				last_q <= last_of_file;
				idx_q  <= '0;
			end else if (cmd.load) begin
				idx_q <= idx_nxt;
			end
			if (cmd.finish) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
		end
	end

	assign total_m1     = IW'(HEADER_BYTES) + IW'(len_q) - IW'(1);
	assign sts.last_idx = (idx_q == total_m1);

	// Payload buffer; the read address runs with the next index so that the
	// registered read data always belongs to the current index.
	assign idx_nxt = idx_q + IW'(1);
	assign idx_rd  = (cmd.load ? idx_nxt : idx_q) - IW'(HEADER_BYTES);

	cps_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.accept),
		.waddr(fill_q[AW-1:0]),
		.wdata(data_byte),
		.raddr(idx_rd[AW-1:0]),
		.rdata(ram_rdata)
	);

	// Primary header bytes.
	assign len_word = 16'(len_q) - 16'd1;
	assign seq_word = {flags_q, seq_q};
	assign hdr[0]   = {{(16 - APID_W){1'b0}}, apid_q[APID_W-1:8]};
	assign hdr[1]   = apid_q[7:0];
	assign hdr[2]   = seq_word[15:8];
	assign hdr[3]   = seq_word[7:0];
	assign hdr[4]   = len_word[15:8];
	assign hdr[5]   = len_word[7:0];

	assign next_byte = (idx_q < IW'(HEADER_BYTES)) ? hdr[idx_q[2:0]] : ram_rdata;

	// Output register, refilled as soon as its byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			packet_byte_q <= next_byte;
			packet_end_q  <= sts.last_idx;
			file_end_q    <= sts.last_idx && last_q;
		end
	end

	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign packet_byte  = packet_byte_q;
	assign packet_end   = packet_end_q;
	assign file_end     = file_end_q;

endmodule

>>> design/cps_ctrl.sv
// Controller of the packet segmenter: takes bytes, then sequences a packet out.
module cps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	input  cps_pkg::cps_sts_t sts,
	output cps_pkg::cps_cmd_t cmd
);
	import cps_pkg::*;

	localparam logic ST_ACCEPT = 1'b0;
	localparam logic ST_EMIT   = 1'b1;

	logic state_q;
	logic state_d;

	// Command decode.
	always_comb begin
		in_ready   = (state_q == ST_ACCEPT);
		cmd.accept = in_ready && in_valid;
		cmd.start  = cmd.accept && sts.flush;
		cmd.load   = (state_q == ST_EMIT) && (!sts.out_full || out_ready);
		cmd.finish = cmd.load && sts.last_idx;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: if (cmd.start) begin
				state_d = ST_EMIT;
			end
			ST_EMIT: if (cmd.finish) begin
				state_d = ST_ACCEPT;
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/cps_checker.sv
// Port-level checker for the packet segmenter and its bind to the top level.
`include "ccsds_packet_segmenter_defines.svh"

module cps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       last_of_file,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] packet_byte,
	input logic       packet_end,
	input logic       file_end
);

	// A stalled result transaction keeps its payload.
	`CPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packet_byte) && $stable(packet_end) && $stable(file_end), "stalled output changed")

	// The end of a file is always the end of a packet.
	`CPS_ASSERT_SAME(a_file_end_pkt, out_valid && file_end, packet_end, "file_end without packet_end")

	// The last byte of a file starts a packet, so intake stops.
	`CPS_ASSERT_NEXT(a_last_stops_in, in_valid && in_ready && last_of_file, !in_ready, "input still taken after last byte")

endmodule

bind ccsds_packet_segmenter cps_checker u_cps_checker (.*);

>>> tb/sv/testbench.sv
// Self-checking testbench for the CCSDS space packet segmenter.
`timescale 1ns / 1ps

module testbench;
	import cps_pkg::*;

	localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
	localparam int MAX_WAIT = 16;

	// The two index codes past the defined registers, which the block ignores.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// One byte of file contents with its control flags.
	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       restart;
	} file_byte_t;

	// One byte of an emitted packet.
	typedef struct {
		logic [7:0] value;
		logic       pkt_end;
		logic       file_done;
	} packet_byte_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            data_byte = '0;
	logic                  last_of_file = 1'b0;
	logic                  restart_count = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            packet_byte;
	logic                  packet_end;
	logic                  file_end;

	// Shadow copy of the segmenter's registers and state.
	logic [APID_W-1:0]  shadow_apid = APID_RST;
	logic [FLAGS_W-1:0] shadow_flags = FLAGS_RST;
	logic [7:0]         shadow_payload [PAYLOAD_BYTES];
	int                 shadow_fill = 0;
	logic [SEQ_W-1:0]   shadow_seq = '0;

	file_byte_t   file_bytes_to_send [$];
	packet_byte_t packet_bytes_due [$];
	packet_byte_t due;
	file_byte_t   next_byte;

	int  items_queued = 0;
	int  items_accepted = 0;
	int  bytes_checked = 0;
	int  packets_checked = 0;
	int  files_checked = 0;
	int  register_writes = 0;
	int  failures = 0;
	int  in_gap = 0;
	int  out_stall = 0;
	bit  in_quiet = 1'b0;
	bit  out_quiet = 1'b0;
	bit  no_idle = 1'b0;

	ccsds_packet_segmenter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_of_file(last_of_file),
		.restart_count(restart_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.packet_byte(packet_byte),
		.packet_end(packet_end),
		.file_end(file_end)
	);

	// Clock generation.
	initial begin
		forever #1 clk = ~clk;
	end

	// Draws the number of idle cycles before the next transaction on one side.
	function automatic int draw_wait(input bit quiet);
		if (quiet || no_idle) begin
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Buffers one file byte and, when a packet completes, queues its header and payload.
	task automatic segment_file_byte(input file_byte_t fb);
		logic [15:0] seq_word;
		logic [15:0] len_word;
		logic [7:0]  header [HEADER_BYTES];
		int          total;
		if (fb.restart) begin
			shadow_seq = '0;
		end
		if (shadow_fill < PAYLOAD_BYTES) begin
			shadow_payload[shadow_fill] = fb.data;
			shadow_fill++;
		end
		if (shadow_fill == PAYLOAD_BYTES || fb.last) begin
			seq_word = {shadow_flags, shadow_seq};
			len_word = 16'(shadow_fill - 1);
			header[0] = {5'b0, shadow_apid[10:8]};
			header[1] = shadow_apid[7:0];
			header[2] = seq_word[15:8];
			header[3] = seq_word[7:0];
			header[4] = len_word[15:8];
			header[5] = len_word[7:0];
			total = HEADER_BYTES + shadow_fill;
			for (int i = 0; i < total; i++) begin
				packet_bytes_due.insert(packet_bytes_due.size(), packet_byte_t'{
					(i < HEADER_BYTES) ? header[i] : shadow_payload[i - HEADER_BYTES],
					(i == total - 1),
					(i == total - 1) && fb.last});
			end
			shadow_seq = shadow_seq + 1'b1;
			shadow_fill = 0;
		end
	endtask

	// Writes one configuration register and mirrors it in the shadow copy.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_APID: shadow_apid = value[APID_W-1:0];
			REG_FLAGS: shadow_flags = value[FLAGS_W-1:0];
			default: ;
		endcase
		register_writes++;
	endtask

	task automatic push_byte(input logic [7:0] data, input logic last, input logic restart);
		file_bytes_to_send.insert(file_bytes_to_send.size(), file_byte_t'{data, last, restart});
		items_queued++;
	endtask

	// Queues whole files of random length and contents until about n bytes are queued.
	task automatic queue_random_files(input int n);
		int added;
		int len;
		int pick;
		bit folder_start;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(0, 9);
			if (added == 0 || pick < 2) begin
				len = PAYLOAD_BYTES * (1 + $urandom_range(0, 1));
			end else if (pick < 4) begin
				len = $urandom_range(1, 3);
			end else begin
				len = $urandom_range(1, 40);
			end
			folder_start = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < len; i++) begin
				push_byte(8'($urandom), (i == len - 1),
					(i == 0) ? folder_start : ($urandom_range(0, 24) == 0));
			end
			added += len;
		end
	endtask

	// Waits until every queued byte is taken and every packet byte has come out.
	task automatic wait_idle();
		while (items_accepted != items_queued || packet_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Input driver: presents queued file bytes with random gaps between transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= '0;
			last_of_file <= 1'b0;
			restart_count <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				segment_file_byte(file_byte_t'{data_byte, last_of_file, restart_count});
				items_accepted++;
				if ($urandom_range(0, 23) == 0) begin
					in_quiet = !in_quiet;
				end
				in_gap = draw_wait(in_quiet);
			end
			if (!in_valid || in_ready) begin
				if (in_gap == 0 && file_bytes_to_send.size() != 0) begin
					next_byte = file_bytes_to_send.pop_front();
					data_byte <= next_byte.data;
					last_of_file <= next_byte.last;
					restart_count <= next_byte.restart;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
					if (in_gap > 0) begin
						in_gap--;
					end
				end
			end
		end
	end

	// Output monitor: stalls at random and checks each packet byte against the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (packet_bytes_due.size() == 0) begin
					$error("unexpected packet byte %0h (packet_end %0b, file_end %0b)",
						packet_byte, packet_end, file_end);
					failures++;
				end else begin
					due = packet_bytes_due.pop_front();
					if (packet_byte !== due.value) begin
						$error("packet_byte: expected %0h, got %0h", due.value, packet_byte);
						failures++;
					end
					if (packet_end !== due.pkt_end) begin
						$error("packet_end: expected %0b, got %0b", due.pkt_end, packet_end);
						failures++;
					end
					if (file_end !== due.file_done) begin
						$error("file_end: expected %0b, got %0b", due.file_done, file_end);
						failures++;
					end
				end
				bytes_checked++;
				packets_checked += packet_end;
				files_checked += file_end;
				if ($urandom_range(0, 23) == 0) begin
					out_quiet = !out_quiet;
				end
				out_stall = draw_wait(out_quiet);
			end
			if (out_stall == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				out_stall--;
			end
		end
	end

	// Stimulus: directed files, then random files under several register settings.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: one-byte files, and a restart while a partial packet is pending.
		push_byte(8'h00, 1'b1, 1'b0);
		push_byte(8'hFF, 1'b1, 1'b1);
		push_byte(8'hA5, 1'b0, 1'b0);
		push_byte(8'h5A, 1'b0, 1'b0);
		push_byte(8'h01, 1'b0, 1'b1);
		push_byte(8'hFE, 1'b1, 1'b0);
		wait_idle();

		// Largest APID, flags masked from a wide value, writes to the unused indexes.
		write_register(REG_APID, 11'h7FF);
		write_register(REG_FLAGS, 11'h7FF);
		write_register(REG_SPARE_A, 11'($urandom));
		write_register(REG_SPARE_B, 11'($urandom));
		queue_random_files(55);
		wait_idle();

		// Smallest values.
		write_register(REG_APID, 11'h000);
		write_register(REG_FLAGS, 11'h000);
		queue_random_files(55);
		wait_idle();

		// Random values with no idle cycles on either side.
		no_idle = 1'b1;
		write_register(REG_APID, 11'($urandom));
		write_register(REG_FLAGS, 11'($urandom));
		queue_random_files(55);
		wait_idle();
		no_idle = 1'b0;

		write_register(REG_APID, 11'($urandom));
		write_register(REG_FLAGS, {9'($urandom), 2'($urandom_range(1, 2))});
		queue_random_files(55);
		wait_idle();

		repeat (16) @(posedge clk);
		$display("Sent %0d file bytes under %0d register writes; checked %0d packet bytes",
			items_accepted, register_writes, bytes_checked);
		$display("in %0d packets, %0d of them closing a file.", packets_checked, files_checked);
		if (failures == 0 && packet_bytes_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#3_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
